>>> rtl/hpr_pkg.sv
// shared types and constants for the hello packet receiver
package hpr_pkg;

    localparam int unsigned NUM_WORDS = 9;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MAX_TRIES   = 2'd0,
        CFG_HEADER_WAIT = 2'd1,
        CFG_JUNK_WAIT   = 2'd2,
        CFG_BYTE_GAP    = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] STATUS_BUSY  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam logic [7:0] CH_ENQ   = 8'h05;
    localparam logic [7:0] CH_ACK   = 8'h06;
    localparam logic [7:0] CH_NAK   = 8'h3f;
    localparam logic [7:0] CH_XON   = 8'h11;
    localparam logic [7:0] CH_XOFF  = 8'h13;
    localparam logic [7:0] CH_START = 8'h1f;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] WORD_OFFSETS [NUM_WORDS] = '{
        8'd2, 8'd4, 8'd6, 8'd8, 8'd90, 8'd92, 8'd94, 8'd96, 8'd114
    };

    localparam logic [3:0] RST_MAX_TRIES   = 4'd3;
    localparam logic [7:0] RST_HEADER_WAIT = 8'd120;
    localparam logic [7:0] RST_JUNK_WAIT   = 8'd10;
    localparam logic [7:0] RST_BYTE_GAP    = 8'd30;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [1:0]  status;
        logic [15:0] hello_version;
        logic [15:0] partner_product;
        logic [15:0] version_major;
        logic [15:0] version_minor;
        logic [15:0] zone_number;
        logic [15:0] net_number;
        logic [15:0] node_number;
        logic [15:0] point_number;
        logic [15:0] capability_bits;
    } t_out_item;

endpackage

>>> rtl/hpr_crc_step.sv
// bytewise crc-16/xmodem update
module hpr_crc_step
    import hpr_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    logic [15:0] v_crc;

    always_comb begin
        v_crc = i_crc ^ {i_byte, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (v_crc[15]) begin
                v_crc = {v_crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                v_crc = {v_crc[14:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule

>>> rtl/hello_packet_receiver_unit.sv
// hello packet receiver: handshake sequencer with packet capture and crc check
// an accepted item is held in the input register; its result then enters the output register
// throughput: one item per cycle unless output stalls; crc and state step are combinational
// the input stalls only when the output item is not taken and the input stage is full
// reset (synchronous, active low) clears the phase, timers, counters and captured words
// and loads the configuration registers with their default values
module hello_packet_receiver_unit
    import hpr_pkg::*;
#(
    parameter int unsigned PACKET_LEN = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    localparam int unsigned POS_W = $clog2(PACKET_LEN + 2);
    localparam logic [POS_W-1:0] LEN_POS = POS_W'(PACKET_LEN);

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT, PH_JUNK, PH_RECV, PH_DONE, PH_ERR
    } t_phase;

    // configuration
    logic [3:0] r_max_tries;
    logic [7:0] r_header_wait, r_junk_wait, r_byte_gap;

    // input stage
    logic     r_in_valid;
    t_in_item r_in_item;

    // output stage
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    // handshake state
    t_phase           r_phase, n_phase;
    logic [3:0]       r_try, n_try;
    logic [7:0]       r_hdr_tmr, n_hdr_tmr;
    logic [7:0]       r_junk_tmr, n_junk_tmr;
    logic [7:0]       r_gap_tmr, n_gap_tmr;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_crc_hi, n_crc_hi;
    logic [7:0]       r_low_hold, n_low_hold;
    logic [15:0]      r_words [NUM_WORDS];
    logic [15:0]      n_words [NUM_WORDS];

    logic        advance;
    logic [15:0] crc_next;
    logic        active;
    logic [3:0]  try_inc;
    logic        done_next;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    hpr_crc_step u_crc (
        .i_crc  (r_crc),
        .i_byte (r_in_item.rx_byte),
        .o_crc  (crc_next)
    );

    assign active  = (r_phase == PH_WAIT) || (r_phase == PH_JUNK) || (r_phase == PH_RECV);
    assign try_inc = r_try + 4'd1;

    always_comb begin
        n_phase    = r_phase;
        n_try      = r_try;
        n_hdr_tmr  = r_hdr_tmr;
        n_junk_tmr = r_junk_tmr;
        n_gap_tmr  = r_gap_tmr;
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_crc_hi   = r_crc_hi;
        n_low_hold = r_low_hold;
        for (int i = 0; i < NUM_WORDS; i++) begin
            n_words[i] = r_words[i];
        end
        n_out_item          = '0;
        n_out_item.tx_valid = 1'b0;
        n_out_item.tx_byte  = 8'h00;

        unique case (t_mode'(r_in_item.mode))
            MODE_START: begin
                for (int i = 0; i < NUM_WORDS; i++) begin
                    n_words[i] = 16'h0000;
                end
                n_try = 4'd1;
                if (4'd1 > r_max_tries) begin
                    n_phase = PH_ERR;
                end else begin
                    n_out_item.tx_valid = 1'b1;
                    n_out_item.tx_byte  = CH_ENQ;
                    n_hdr_tmr           = r_header_wait;
                    n_phase             = PH_WAIT;
                end
            end
            MODE_TICK: begin
                if (active) begin
                    if (r_hdr_tmr != 8'd0) begin
                        n_hdr_tmr = r_hdr_tmr - 8'd1;
                    end
                    if (r_phase == PH_WAIT) begin
                        if (n_hdr_tmr == 8'd0) begin
                            n_phase = PH_ERR;
                        end
                    end else if (r_phase == PH_JUNK) begin
                        if (r_junk_tmr != 8'd0) begin
                            n_junk_tmr = r_junk_tmr - 8'd1;
                        end
                        if (n_junk_tmr == 8'd0) begin
                            // junk wait over: retry with a fresh enq, or error once the tries run out
                            n_try = try_inc;
                            if (try_inc == 4'd0 || try_inc > r_max_tries) begin
                                n_phase = PH_ERR;
                            end else begin
                                n_out_item.tx_valid = 1'b1;
                                n_out_item.tx_byte  = CH_ENQ;
                                n_hdr_tmr           = r_header_wait;
                                n_phase             = PH_WAIT;
                            end
                        end
                    end else begin
                        if (r_gap_tmr != 8'd0) begin
                            n_gap_tmr = r_gap_tmr - 8'd1;
                        end
                        if (n_gap_tmr == 8'd0) begin
                            n_phase = PH_ERR;
                        end
                    end
                end
            end
            MODE_BYTE: begin
                if (active) begin
                    if (r_phase == PH_WAIT || r_phase == PH_JUNK) begin
                        if (r_in_item.rx_byte == CH_START) begin
                            n_phase   = PH_RECV;
                            n_pos     = '0;
                            n_crc     = 16'h0000;
                            n_crc_hi  = 8'h00;
                            n_gap_tmr = r_byte_gap;
                        end else if (r_phase == PH_WAIT &&
                                     r_in_item.rx_byte != CH_XON &&
                                     r_in_item.rx_byte != CH_XOFF) begin
                            n_junk_tmr = r_junk_wait;
                            n_phase    = PH_JUNK;
                        end
                    end else begin
                        n_gap_tmr = r_byte_gap;
                        if (r_pos < LEN_POS) begin
                            n_crc = crc_next;
                            for (int i = 0; i < NUM_WORDS; i++) begin
                                if (r_pos == POS_W'(WORD_OFFSETS[i])) begin
                                    n_low_hold = r_in_item.rx_byte;
                                end else if (r_pos == POS_W'(WORD_OFFSETS[i] + 8'd1)) begin
                                    n_words[i] = {r_in_item.rx_byte, r_low_hold};
                                end
                            end
                            n_pos = r_pos + POS_W'(1);
                        end else if (r_pos == LEN_POS) begin
                            n_crc_hi = r_in_item.rx_byte;
                            n_pos    = r_pos + POS_W'(1);
                        end else begin
                            // crc trailer complete: answer ack or '?'
                            n_out_item.tx_valid = 1'b1;
                            if ({r_crc_hi, r_in_item.rx_byte} == r_crc) begin
                                n_out_item.tx_byte = CH_ACK;
                                n_phase            = PH_DONE;
                            end else begin
                                n_out_item.tx_byte = CH_NAK;
                                n_phase = (r_hdr_tmr == 8'd0) ? PH_ERR : PH_WAIT;
                            end
                        end
                    end
                end
            end
            MODE_NONE: begin
            end
            default: begin
            end
        endcase

        done_next = (n_phase == PH_DONE);
        if (done_next) begin
            n_out_item.status = STATUS_DONE;
        end else if (n_phase == PH_ERR) begin
            n_out_item.status = STATUS_ERROR;
        end else begin
            n_out_item.status = STATUS_BUSY;
        end
        if (done_next) begin
            n_out_item.hello_version   = n_words[0];
            n_out_item.partner_product = n_words[1];
            n_out_item.version_major   = n_words[2];
            n_out_item.version_minor   = n_words[3];
            n_out_item.zone_number     = n_words[4];
            n_out_item.net_number      = n_words[5];
            n_out_item.node_number     = n_words[6];
            n_out_item.point_number    = n_words[7];
            n_out_item.capability_bits = n_words[8];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tries   <= RST_MAX_TRIES;
            r_header_wait <= RST_HEADER_WAIT;
            r_junk_wait   <= RST_JUNK_WAIT;
            r_byte_gap    <= RST_BYTE_GAP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_TRIES:   r_max_tries   <= i_cfg_data[3:0];
                CFG_HEADER_WAIT: r_header_wait <= i_cfg_data;
                CFG_JUNK_WAIT:   r_junk_wait   <= i_cfg_data;
                CFG_BYTE_GAP:    r_byte_gap    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input and output stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    // handshake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_try      <= 4'd0;
            r_hdr_tmr  <= 8'd0;
            r_junk_tmr <= 8'd0;
            r_gap_tmr  <= 8'd0;
            r_pos      <= '0;
            r_crc      <= 16'h0000;
            r_crc_hi   <= 8'h00;
            r_low_hold <= 8'h00;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_words[i] <= 16'h0000;
            end
        end else if (advance) begin
            r_phase    <= n_phase;
            r_try      <= n_try;
            r_hdr_tmr  <= n_hdr_tmr;
            r_junk_tmr <= n_junk_tmr;
            r_gap_tmr  <= n_gap_tmr;
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_crc_hi   <= n_crc_hi;
            r_low_hold <= n_low_hold;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_words[i] <= n_words[i];
            end
        end
    end

endmodule
